// ----- hdl/lcd_scanline_mode_sequencer_core_macros.svh -----
// Assertion macros shared by the scanline mode sequencer RTL.
`ifndef LCD_SCANLINE_MODE_SEQUENCER_CORE_MACROS_SVH
`define LCD_SCANLINE_MODE_SEQUENCER_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LCDSMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define LCDSMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lcdsms_pkg.sv -----
// Package with types and constants of the scanline mode sequencer.
`default_nettype none

package lcdsms_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_XFER   = 2'd3
    } lcdsms_mode_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_SEARCH_DOTS   = 3'd0;
    localparam logic [2:0] REG_TRANSFER_DOTS = 3'd1;
    localparam logic [2:0] REG_LINE_DOTS     = 3'd2;
    localparam logic [2:0] REG_VBLANK_FIRST  = 3'd3;
    localparam logic [2:0] REG_FINAL_LINE    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int DOT_COUNTER_BITS_DEFAULT = 10;

    localparam logic [7:0] SEARCH_DOTS_RESET   = 8'd80;
    localparam logic [8:0] TRANSFER_DOTS_RESET = 9'd172;
    localparam logic [9:0] LINE_DOTS_RESET     = 10'd456;
    localparam logic [7:0] VBLANK_FIRST_RESET  = 8'd144;
    localparam logic [7:0] FINAL_LINE_RESET    = 8'd153;

    typedef struct packed {
        logic [7:0]  search_dots;
        logic [8:0]  transfer_dots;
        logic [9:0]  line_dots;
        logic [7:0]  vblank_first_line;
        logic [7:0]  final_line;
    } lcdsms_cfg_t;

    typedef struct packed {
        logic vblank_irq;
        logic render_request;
    } lcdsms_flags_t;

endpackage

`default_nettype wire

// ----- hdl/lcd_scanline_mode_sequencer_core.sv -----
// Scanline mode sequencer for a handheld LCD controller.
//
// Each input item is one dot-clock tick carrying display_enable. The block
// steps its mode, dot counter and line number and returns one result item per
// tick: mode_out, line_out, vblank_irq and render_request.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. A result appears in the cycle after its tick is taken, from
// an output register. One tick is taken every cycle unless stalled: the state
// update is a single compare-and-increment step between the state registers
// and the output register. A new tick is refused only while a result is
// waiting and out_stall is high; results are neither dropped nor repeated
// while stalled. The configuration port writes one timing register per cycle
// through cfg_we, cfg_index and cfg_data; indexes beyond the list are ignored.
// Reset restores the default timings (80, 172, 456, 144, 153), sets the mode
// to object search at line 0 with the dot counter cleared, and empties the
// output register.
`default_nettype none

module lcd_scanline_mode_sequencer_core #(
    parameter int DOT_COUNTER_BITS = lcdsms_pkg::DOT_COUNTER_BITS_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [lcdsms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [lcdsms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               display_enable,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [1:0]                        mode_out,
    output logic [7:0]                        line_out,
    output logic                              vblank_irq,
    output logic                              render_request
);
    import lcdsms_pkg::*;

    `include "lcd_scanline_mode_sequencer_core_macros.svh"

    lcdsms_cfg_t                 cfg_reg;
    lcdsms_mode_t                mode_reg;
    lcdsms_mode_t                mode_next;
    logic [DOT_COUNTER_BITS-1:0] dots_reg;
    logic [DOT_COUNTER_BITS-1:0] dots_next;
    logic [7:0]                  line_reg;
    logic [7:0]                  line_next;
    lcdsms_flags_t               flags_next;
    logic                        out_valid_reg;
    lcdsms_mode_t                out_mode_reg;
    logic [7:0]                  out_line_reg;
    lcdsms_flags_t               out_flags_reg;
    logic                        accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_dots       <= SEARCH_DOTS_RESET;
            cfg_reg.transfer_dots     <= TRANSFER_DOTS_RESET;
            cfg_reg.line_dots         <= LINE_DOTS_RESET;
            cfg_reg.vblank_first_line <= VBLANK_FIRST_RESET;
            cfg_reg.final_line        <= FINAL_LINE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEARCH_DOTS:   cfg_reg.search_dots       <= cfg_data[7:0];
                REG_TRANSFER_DOTS: cfg_reg.transfer_dots     <= cfg_data[8:0];
                REG_LINE_DOTS:     cfg_reg.line_dots         <= cfg_data[9:0];
                REG_VBLANK_FIRST:  cfg_reg.vblank_first_line <= cfg_data[7:0];
                REG_FINAL_LINE:    cfg_reg.final_line        <= cfg_data[7:0];
                default:           cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    lcdsms_step #(
        .DOT_COUNTER_BITS(DOT_COUNTER_BITS)
    ) u_step (
        .display_enable(display_enable),
        .cfg           (cfg_reg),
        .mode_cur      (mode_reg),
        .dots_cur      (dots_reg),
        .line_cur      (line_reg),
        .mode_nxt      (mode_next),
        .dots_nxt      (dots_next),
        .line_nxt      (line_next),
        .flags         (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SEARCH;
            dots_reg      <= '0;
            line_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            dots_reg      <= dots_next;
            line_reg      <= line_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload loads with each taken tick and holds otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_mode_reg  <= mode_next;
            out_line_reg  <= line_next;
            out_flags_reg <= flags_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_out       = out_mode_reg;
    assign line_out       = out_line_reg;
    assign vblank_irq     = out_flags_reg.vblank_irq;
    assign render_request = out_flags_reg.render_request;

    `LCDSMS_ASSERT(a_irq_in_vblank,
        !(out_valid_reg && out_flags_reg.vblank_irq) || (out_mode_reg == MODE_VBLANK),
        "vblank interrupt raised outside vertical blank")
    `LCDSMS_ASSERT(a_req_in_hblank,
        !(out_valid_reg && out_flags_reg.render_request) || (out_mode_reg == MODE_HBLANK),
        "render request raised outside horizontal blank")
    `LCDSMS_ASSERT_NEXT(a_disable_clears, accept && !display_enable,
        (mode_reg == MODE_HBLANK) && (line_reg == 8'd0) && (dots_reg == '0),
        "disabled tick did not clear the sequencer state")
    `LCDSMS_ASSERT_NEXT(a_state_holds, !accept,
        $stable(mode_reg) && $stable(line_reg) && $stable(dots_reg),
        "sequencer state moved without a taken tick")

endmodule

`default_nettype wire

// ----- hdl/lcdsms_step.sv -----
// Next-state logic for one dot tick of the scanline mode sequencer.
`default_nettype none

module lcdsms_step #(
    parameter int DOT_COUNTER_BITS = lcdsms_pkg::DOT_COUNTER_BITS_DEFAULT
) (
    input  wire                               display_enable,
    input  wire lcdsms_pkg::lcdsms_cfg_t      cfg,
    input  wire lcdsms_pkg::lcdsms_mode_t     mode_cur,
    input  wire [DOT_COUNTER_BITS-1:0]        dots_cur,
    input  wire [7:0]                         line_cur,
    output lcdsms_pkg::lcdsms_mode_t          mode_nxt,
    output logic [DOT_COUNTER_BITS-1:0]       dots_nxt,
    output logic [7:0]                        line_nxt,
    output lcdsms_pkg::lcdsms_flags_t         flags
);
    import lcdsms_pkg::*;

    localparam int CMP_W = (DOT_COUNTER_BITS > 10) ? DOT_COUNTER_BITS : 10;
    localparam logic [DOT_COUNTER_BITS-1:0] DOTS_MAX = {DOT_COUNTER_BITS{1'b1}};

    logic [DOT_COUNTER_BITS-1:0] dots_inc;
    logic [CMP_W-1:0]            dots_cmp;
    logic [9:0]                  xfer_end;
    logic [7:0]                  line_inc;
    logic                        search_done;
    logic                        xfer_done;
    logic                        line_done;

    // The counter saturates so that an unreachable threshold holds the mode.
    assign dots_inc = (dots_cur == DOTS_MAX) ? dots_cur : dots_cur + 1'b1;
    assign dots_cmp = CMP_W'(dots_inc);
    assign xfer_end = {2'b00, cfg.search_dots} + {1'b0, cfg.transfer_dots};
    assign line_inc = line_cur + 8'd1;

    assign search_done = dots_cmp >= CMP_W'(cfg.search_dots);
    assign xfer_done   = dots_cmp >= CMP_W'(xfer_end);
    assign line_done   = dots_cmp >= CMP_W'(cfg.line_dots);

    always_comb
    begin
        mode_nxt = mode_cur;
        if (!display_enable)
        begin
            mode_nxt = MODE_HBLANK;
        end
        else
        begin
            case (mode_cur)
                MODE_SEARCH:
                begin
                    if (search_done)
                        mode_nxt = MODE_XFER;
                end
                MODE_XFER:
                begin
                    if (xfer_done)
                        mode_nxt = MODE_HBLANK;
                end
                MODE_HBLANK:
                begin
                    if (line_done)
                        mode_nxt = (line_inc == cfg.vblank_first_line) ? MODE_VBLANK
                                                                       : MODE_SEARCH;
                end
                MODE_VBLANK:
                begin
                    if (line_done && (line_inc > cfg.final_line))
                        mode_nxt = MODE_SEARCH;
                end
                default:
                begin
                    mode_nxt = mode_cur;
                end
            endcase
        end
    end

    always_comb
    begin
        dots_nxt             = dots_inc;
        line_nxt             = line_cur;
        flags.vblank_irq     = 1'b0;
        flags.render_request = 1'b0;
        if (!display_enable)
        begin
            dots_nxt = '0;
            line_nxt = 8'd0;
        end
        else
        begin
            case (mode_cur)
                MODE_XFER:
                begin
                    flags.render_request = xfer_done;
                end
                MODE_HBLANK:
                begin
                    if (line_done)
                    begin
                        dots_nxt         = '0;
                        line_nxt         = line_inc;
                        flags.vblank_irq = (line_inc == cfg.vblank_first_line);
                    end
                end
                MODE_VBLANK:
                begin
                    if (line_done)
                    begin
                        dots_nxt = '0;
                        line_nxt = (line_inc > cfg.final_line) ? 8'd0 : line_inc;
                    end
                end
                default:
                begin
                    dots_nxt = dots_inc;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
